// ===== src/tpc_pkg.sv =====
// Shared types and constants of the triangle plane clipper.
// No dependencies; every other file of the block but tpc_if imports this package.
`default_nettype none

package tpc_pkg;

    localparam int CW  = 32;          // coordinate and colour width
    localparam int NW  = 18;          // normal component width
    localparam int PW  = CW + NW;     // one normal-by-coordinate product
    localparam int SW  = PW + 2;      // sum of three products
    localparam int DW  = SW + 1;      // signed distance
    localparam int EW  = DW + 1;      // numerator and denominator of the lerp
    localparam int MW  = CW + 1;      // magnitude of a coordinate difference
    localparam int NMW = DW;          // magnitude of the numerator
    localparam int QW  = 36;          // quotient bits produced by the divider
    localparam int QCW = 35;          // clamped quotient width
    localparam int LERP_LAT = QW + 4; // register stages through one lerp lane

    localparam logic [QCW-1:0] QLIM = QCW'(64'h4_0000_0000);

    localparam logic [2:0] CFG_POINT_X = 3'd0;
    localparam logic [2:0] CFG_POINT_Y = 3'd1;
    localparam logic [2:0] CFG_POINT_Z = 3'd2;
    localparam logic [2:0] CFG_NORM_X  = 3'd3;
    localparam logic [2:0] CFG_NORM_Y  = 3'd4;
    localparam logic [2:0] CFG_NORM_Z  = 3'd5;
    localparam logic [2:0] CFG_SHOW    = 3'd6;

    localparam logic [CW-1:0] COL_GREEN = 32'hFF00FF00;
    localparam logic [CW-1:0] COL_RED   = 32'hFF0000FF;
    localparam logic [CW-1:0] COL_BLUE  = 32'hFFFF0000;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [DW-1:0] dist_t;
    typedef coord_t [2:0] vec_t;      // [0] x, [1] y, [2] z

    typedef struct packed {
        coord_t          a_x;
        coord_t          a_y;
        coord_t          a_z;
        coord_t          b_x;
        coord_t          b_y;
        coord_t          b_z;
        coord_t          c_x;
        coord_t          c_y;
        coord_t          c_z;
        logic [CW-1:0]   a_color;
        logic [CW-1:0]   b_color;
        logic [CW-1:0]   c_color;
    } tri_in_t;

    typedef struct packed {
        coord_t          out_x;
        coord_t          out_y;
        coord_t          out_z;
        logic [CW-1:0]   out_color;
        logic [1:0]      corner;
        logic            last;
    } vtx_out_t;

    typedef struct packed {
        coord_t              px;
        coord_t              py;
        coord_t              pz;
        logic signed [NW-1:0] nx;
        logic signed [NW-1:0] ny;
        logic signed [NW-1:0] nz;
    } plane_t;

    typedef enum logic [1:0] {
        CLIP_NONE,
        CLIP_ALL,
        CLIP_TWO,
        CLIP_ONE
    } clip_case_t;

    // Vertices and colours in emission order: kept corners first, then cut ones
    typedef struct packed {
        clip_case_t            mode;
        vec_t [2:0]            p;
        logic [2:0][CW-1:0]    k;
    } plan_t;

    typedef struct packed {
        coord_t                s;
        logic signed [CW:0]    delta;
        logic signed [EW-1:0]  num;
        logic signed [EW-1:0]  den;
    } lerp_in_t;

endpackage

`default_nettype wire

// ===== src/tpc_if.sv =====
// Valid/ready channel carrying one request payload.
// Payload type is a parameter; normally a struct from tpc_pkg.
`default_nettype none

interface tpc_if #(parameter type data_t = logic);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/tpc_dist.sv =====
// Three-stage signed distance of the three vertices to the clip plane.
// Depends on tpc_pkg; carries the triangle alongside the distances.
`default_nettype none

module tpc_dist (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  tpc_pkg::tri_in_t   in_tri,
    input  tpc_pkg::plane_t    plane,
    output logic               out_valid,
    output tpc_pkg::tri_in_t   out_tri,
    output tpc_pkg::dist_t [2:0] vdist
);
    import tpc_pkg::*;

    vec_t                  vtx [3];
    logic signed [PW-1:0]  prod_next [4][3];
    logic signed [PW-1:0]  prod_reg  [4][3];
    logic signed [SW-1:0]  sum_reg   [4];
    dist_t                 dist_reg  [3];
    tri_in_t               tri1_reg, tri2_reg, tri3_reg;
    logic [2:0]            valid_reg;

    always_comb
    begin
        vtx[0] = {in_tri.a_z, in_tri.a_y, in_tri.a_x};
        vtx[1] = {in_tri.b_z, in_tri.b_y, in_tri.b_x};
        vtx[2] = {in_tri.c_z, in_tri.c_y, in_tri.c_x};
        for (int i = 0; i < 3; i++)
        begin
            prod_next[i][0] = PW'(plane.nx) * PW'($signed(vtx[i][0]));
            prod_next[i][1] = PW'(plane.ny) * PW'($signed(vtx[i][1]));
            prod_next[i][2] = PW'(plane.nz) * PW'($signed(vtx[i][2]));
        end
        // plane offset n.q rides in the fourth row
        prod_next[3][0] = PW'(plane.nx) * PW'(plane.px);
        prod_next[3][1] = PW'(plane.ny) * PW'(plane.py);
        prod_next[3][2] = PW'(plane.nz) * PW'(plane.pz);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tri1_reg <= in_tri;
            tri2_reg <= tri1_reg;
            tri3_reg <= tri2_reg;
            prod_reg <= prod_next;
            for (int i = 0; i < 4; i++)
            begin
                sum_reg[i] <= SW'(prod_reg[i][0]) + SW'(prod_reg[i][1])
                            + SW'(prod_reg[i][2]);
            end
            for (int i = 0; i < 3; i++)
            begin
                dist_reg[i] <= DW'(sum_reg[i]) - DW'(sum_reg[3]);
            end
        end
    end

    assign out_valid = valid_reg[2];
    assign out_tri   = tri3_reg;
    assign vdist[0]  = dist_reg[0];
    assign vdist[1]  = dist_reg[1];
    assign vdist[2]  = dist_reg[2];

endmodule

`default_nettype wire

// ===== src/tpc_lerp.sv =====
// One coordinate of a line-plane intersection: s + trunc(delta*num/den),
// saturated. Split multiply, then a one-bit-per-stage restoring divider.
// Depends on tpc_pkg.
`default_nettype none

module tpc_lerp (
    input  logic              clk,
    input  logic              en,
    input  tpc_pkg::lerp_in_t lin,
    output tpc_pkg::coord_t   res
);
    import tpc_pkg::*;

    localparam int LOW = 27;
    localparam int HIW = NMW - LOW;
    localparam int PRW = MW + NMW;

    // magnitude stage
    logic [MW-1:0]   am_next, am_reg;
    logic [NMW-1:0]  nm_next, nm_reg;
    logic [EW-1:0]   dm_next, dm0_reg, dm1_reg;
    logic            neg0_reg, neg1_reg, zero0_reg, zero1_reg;
    coord_t          s0_reg, s1_reg;

    // partial products
    logic [MW+LOW-1:0] plo_reg;
    logic [MW+HIW-1:0] phi_reg;

    // divider stages
    logic [PRW-1:0]  prod;
    logic [EW-1:0]   rem_reg  [QW+1];
    logic [QW-1:0]   low_reg  [QW+1];
    logic [QW-1:0]   q_reg    [QW+1];
    logic [EW-1:0]   dm_reg   [QW+1];
    logic            neg_reg  [QW+1];
    logic            zero_reg [QW+1];
    logic            ovf_reg  [QW+1];
    coord_t          s_reg    [QW+1];
    logic [EW:0]     trial    [QW];
    logic            ge       [QW];

    logic [QCW-1:0]     qc;
    logic signed [CW+4:0] sum;
    coord_t             res_next, res_reg;

    always_comb
    begin
        am_next = lin.delta[CW] ? MW'(-lin.delta) : MW'(lin.delta);
        nm_next = lin.num[EW-1] ? NMW'(-lin.num) : NMW'(lin.num);
        dm_next = lin.den[EW-1] ? EW'(-lin.den) : EW'(lin.den);
        prod    = PRW'(plo_reg) + (PRW'(phi_reg) << LOW);
        for (int i = 0; i < QW; i++)
        begin
            trial[i] = {rem_reg[i], low_reg[i][QW-1]};
            ge[i]    = trial[i] >= {1'b0, dm_reg[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            am_reg    <= am_next;
            nm_reg    <= nm_next;
            dm0_reg   <= dm_next;
            neg0_reg  <= lin.delta[CW] ^ lin.num[EW-1] ^ lin.den[EW-1];
            zero0_reg <= (lin.den == '0);
            s0_reg    <= lin.s;

            plo_reg   <= (MW+LOW)'(am_reg) * (MW+LOW)'(nm_reg[LOW-1:0]);
            phi_reg   <= (MW+HIW)'(am_reg) * (MW+HIW)'(nm_reg[NMW-1:LOW]);
            dm1_reg   <= dm0_reg;
            neg1_reg  <= neg0_reg;
            zero1_reg <= zero0_reg;
            s1_reg    <= s0_reg;

            // a quotient of 2^36 or more only ever saturates
            rem_reg[0]  <= EW'(prod[PRW-1:QW]);
            ovf_reg[0]  <= EW'(prod[PRW-1:QW]) >= dm1_reg;
            low_reg[0]  <= prod[QW-1:0];
            q_reg[0]    <= '0;
            dm_reg[0]   <= dm1_reg;
            neg_reg[0]  <= neg1_reg;
            zero_reg[0] <= zero1_reg;
            s_reg[0]    <= s1_reg;

            for (int i = 0; i < QW; i++)
            begin
                rem_reg[i+1]  <= ge[i] ? EW'(trial[i] - {1'b0, dm_reg[i]})
                                       : EW'(trial[i]);
                low_reg[i+1]  <= {low_reg[i][QW-2:0], 1'b0};
                q_reg[i+1]    <= {q_reg[i][QW-2:0], ge[i]};
                dm_reg[i+1]   <= dm_reg[i];
                neg_reg[i+1]  <= neg_reg[i];
                zero_reg[i+1] <= zero_reg[i];
                ovf_reg[i+1]  <= ovf_reg[i];
                s_reg[i+1]    <= s_reg[i];
            end

            res_reg <= res_next;
        end
    end

    always_comb
    begin
        if (zero_reg[QW])
            qc = '0;
        else if (ovf_reg[QW] || q_reg[QW] > QW'(QLIM))
            qc = QLIM;
        else
            qc = q_reg[QW][QCW-1:0];

        if (neg_reg[QW])
            sum = (CW+5)'(s_reg[QW]) - $signed((CW+5)'(qc));
        else
            sum = (CW+5)'(s_reg[QW]) + $signed((CW+5)'(qc));

        if (sum > (CW+5)'(coord_t'({1'b0, {(CW-1){1'b1}}})))
            res_next = {1'b0, {(CW-1){1'b1}}};
        else if (sum < (CW+5)'(coord_t'({1'b1, {(CW-1){1'b0}}})))
            res_next = {1'b1, {(CW-1){1'b0}}};
        else
            res_next = sum[CW-1:0];
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ===== src/tpc_emit.sv =====
// Output register stage: holds one clipped triangle plan and sends its
// vertices one request per cycle while out_ready is high. Depends on tpc_pkg.
`default_nettype none

module tpc_emit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  tpc_pkg::plan_t     in_plan,
    input  tpc_pkg::vec_t      in_x0,
    input  tpc_pkg::vec_t      in_x1,
    input  logic               show,
    output logic               take,
    output logic               out_valid,
    output tpc_pkg::vtx_out_t  out_data,
    input  logic               out_ready
);
    import tpc_pkg::*;

    logic        busy_reg, busy_next;
    logic [2:0]  idx_reg, idx_next;
    plan_t       plan_reg;
    vec_t        x0_reg, x1_reg;
    logic        final_slot;
    logic        load;
    vec_t        pos;
    logic [CW-1:0] col;
    logic [1:0]  corner;
    logic [2:0]  last_idx;

    assign last_idx   = (plan_reg.mode == CLIP_TWO) ? 3'd5 : 3'd2;
    assign final_slot = busy_reg && out_ready && (idx_reg == last_idx);
    assign take       = !busy_reg || final_slot;
    assign load       = take && in_valid && (in_plan.mode != CLIP_NONE);

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (final_slot)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg && out_ready)
        begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            plan_reg <= in_plan;
            x0_reg   <= in_x0;
            x1_reg   <= in_x1;
        end
    end

    always_comb
    begin
        pos    = plan_reg.p[0];
        col    = plan_reg.k[0];
        corner = idx_reg[1:0];
        case (plan_reg.mode)
            CLIP_ALL:
            begin
                case (idx_reg)
                    3'd1:    begin pos = plan_reg.p[1]; col = plan_reg.k[1]; end
                    3'd2:    begin pos = plan_reg.p[2]; col = plan_reg.k[2]; end
                    default: begin pos = plan_reg.p[0]; col = plan_reg.k[0]; end
                endcase
            end
            CLIP_ONE:
            begin
                case (idx_reg)
                    3'd1:    begin pos = x0_reg; col = plan_reg.k[1]; end
                    3'd2:    begin pos = x1_reg; col = plan_reg.k[2]; end
                    default: begin pos = plan_reg.p[0]; col = plan_reg.k[0]; end
                endcase
                if (show)
                    col = COL_BLUE;
            end
            CLIP_TWO:
            begin
                // first triangle kept a, kept b, cut a; second kept b, cut a, cut b
                case (idx_reg)
                    3'd1:    begin pos = plan_reg.p[1]; col = plan_reg.k[1]; end
                    3'd2:    begin pos = x0_reg;        col = plan_reg.k[2]; end
                    3'd3:    begin pos = plan_reg.p[1]; col = plan_reg.k[1]; end
                    3'd4:    begin pos = x0_reg;        col = plan_reg.k[2]; end
                    3'd5:    begin pos = x1_reg;        col = plan_reg.k[2]; end
                    default: begin pos = plan_reg.p[0]; col = plan_reg.k[0]; end
                endcase
                if (idx_reg > 3'd2)
                    corner = 2'(idx_reg - 3'd3);
                if (show)
                    col = (idx_reg > 3'd2) ? COL_RED : COL_GREEN;
            end
            default:
            begin
                pos = plan_reg.p[0];
            end
        endcase
    end

    assign out_valid          = busy_reg;
    assign out_data.out_x     = pos[0];
    assign out_data.out_y     = pos[1];
    assign out_data.out_z     = pos[2];
    assign out_data.out_color = col;
    assign out_data.corner    = corner;
    assign out_data.last      = (idx_reg == last_idx);

endmodule

`default_nettype wire

// ===== src/triangle_plane_clipper_core.sv =====
// Triangle plane clipper: clips one triangle against a configured plane.
// Depends on tpc_pkg, tpc_if, tpc_dist, tpc_lerp and tpc_emit.
//
// Usage:
//   tri_in  : one request per triangle, three Q16.16 vertices and three
//             packed colours, taken when valid and ready are both high.
//   vtx_out : one request per output vertex with corner index and a last
//             mark on the final vertex of the triangle. A fully inside
//             triangle gives three vertices, a cut one three or six, a
//             fully outside one nothing.
//   cfg_*   : plane point, unit normal and debug colour switch, written by
//             index; write only while no triangle is in flight.
// From accepted triangle to its first vertex the path runs through three
// distance stages, one classify stage, 40 stages per lerp lane (magnitudes,
// split multiply, divider set-up, 36 one-bit divider steps, saturating add)
// and the output register.
// A new triangle enters every cycle while the output stage is free; the
// output stage sends one vertex per cycle while the receiver is ready,
// and the pipeline holds until the last vertex of a triangle is taken.
// Reset clears every valid bit and loads the default plane z = 0 facing +z.
// When the receiver stalls, the whole pipeline holds; nothing is lost.
`default_nettype none

module triangle_plane_clipper_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    tpc_if.sink         tri_in,
    tpc_if.source       vtx_out,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import tpc_pkg::*;

    localparam longint THR     = ((longint'(1) <<< (2 * FRAC_BITS)) + 5) / 10;
    localparam dist_t  NEG_THR = DW'(-THR);

    typedef struct packed {
        clip_case_t  mode;
        logic [1:0]  r0;
        logic [1:0]  r1;
        logic [1:0]  r2;
    } order_t;

    // which vertices are kept, in input order, then which are cut away
    function automatic order_t classify(input logic [2:0] ins);
        order_t o;
        case (ins)
            3'b111:  o = '{CLIP_ALL,  2'd0, 2'd1, 2'd2};
            3'b011:  o = '{CLIP_TWO,  2'd0, 2'd1, 2'd2};
            3'b101:  o = '{CLIP_TWO,  2'd0, 2'd2, 2'd1};
            3'b110:  o = '{CLIP_TWO,  2'd1, 2'd2, 2'd0};
            3'b001:  o = '{CLIP_ONE,  2'd0, 2'd1, 2'd2};
            3'b010:  o = '{CLIP_ONE,  2'd1, 2'd0, 2'd2};
            3'b100:  o = '{CLIP_ONE,  2'd2, 2'd0, 2'd1};
            default: o = '{CLIP_NONE, 2'd0, 2'd1, 2'd2};
        endcase
        return o;
    endfunction

    plane_t          plane_reg;
    logic            show_reg;
    logic            en;

    logic            d_valid;
    tri_in_t         d_tri;
    dist_t [2:0]     d_dist;

    vec_t            vtx  [3];
    logic [CW-1:0]   colr [3];
    logic [2:0]      ins;
    order_t          ord;
    logic [1:0]      s_sel [2];
    logic [1:0]      e_sel [2];
    plan_t           plan_next;
    lerp_in_t        lin_next [6];
    lerp_in_t        lin_reg  [6];
    coord_t          lres     [6];

    logic [LERP_LAT:0] valid_sreg;
    plan_t             plan_sreg [LERP_LAT+1];

    vec_t            x0, x1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg.px <= '0;
            plane_reg.py <= '0;
            plane_reg.pz <= '0;
            plane_reg.nx <= '0;
            plane_reg.ny <= '0;
            plane_reg.nz <= NW'(65536);
            show_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POINT_X: plane_reg.px <= cfg_data;
                CFG_POINT_Y: plane_reg.py <= cfg_data;
                CFG_POINT_Z: plane_reg.pz <= cfg_data;
                CFG_NORM_X:  plane_reg.nx <= cfg_data[NW-1:0];
                CFG_NORM_Y:  plane_reg.ny <= cfg_data[NW-1:0];
                CFG_NORM_Z:  plane_reg.nz <= cfg_data[NW-1:0];
                CFG_SHOW:    show_reg     <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    assign tri_in.ready = en;

    tpc_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (tri_in.valid),
        .in_tri    (tri_in.data),
        .plane     (plane_reg),
        .out_valid (d_valid),
        .out_tri   (d_tri),
        .vdist     (d_dist)
    );

    // classify and set up both cut edges
    always_comb
    begin
        vtx[0]  = {d_tri.a_z, d_tri.a_y, d_tri.a_x};
        vtx[1]  = {d_tri.b_z, d_tri.b_y, d_tri.b_x};
        vtx[2]  = {d_tri.c_z, d_tri.c_y, d_tri.c_x};
        colr[0] = d_tri.a_color;
        colr[1] = d_tri.b_color;
        colr[2] = d_tri.c_color;
        for (int i = 0; i < 3; i++)
        begin
            ins[i] = (d_dist[i] >= NEG_THR);
        end
        ord = classify(ins);

        plan_next.mode = ord.mode;
        plan_next.p[0] = vtx[ord.r0];
        plan_next.p[1] = vtx[ord.r1];
        plan_next.p[2] = vtx[ord.r2];
        plan_next.k[0] = colr[ord.r0];
        plan_next.k[1] = colr[ord.r1];
        plan_next.k[2] = colr[ord.r2];

        s_sel[0] = ord.r0;
        e_sel[0] = (ord.mode == CLIP_TWO) ? ord.r2 : ord.r1;
        s_sel[1] = (ord.mode == CLIP_TWO) ? ord.r1 : ord.r0;
        e_sel[1] = ord.r2;

        for (int j = 0; j < 2; j++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                lin_next[j*3+k].s     = vtx[s_sel[j]][k];
                lin_next[j*3+k].delta = (CW+1)'($signed(vtx[e_sel[j]][k]))
                                      - (CW+1)'($signed(vtx[s_sel[j]][k]));
                lin_next[j*3+k].num   = -EW'(d_dist[s_sel[j]]);
                lin_next[j*3+k].den   = EW'(d_dist[e_sel[j]])
                                      - EW'(d_dist[s_sel[j]]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_sreg <= '0;
        end
        else if (en)
        begin
            valid_sreg <= {valid_sreg[LERP_LAT-1:0], d_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lin_reg      <= lin_next;
            plan_sreg[0] <= plan_next;
            for (int i = 0; i < LERP_LAT; i++)
            begin
                plan_sreg[i+1] <= plan_sreg[i];
            end
        end
    end

    for (genvar g = 0; g < 6; g++)
    begin : g_lane
        tpc_lerp u_lerp (
            .clk (clk),
            .en  (en),
            .lin (lin_reg[g]),
            .res (lres[g])
        );
    end

    assign x0 = {lres[2], lres[1], lres[0]};
    assign x1 = {lres[5], lres[4], lres[3]};

    tpc_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_sreg[LERP_LAT]),
        .in_plan   (plan_sreg[LERP_LAT]),
        .in_x0     (x0),
        .in_x1     (x1),
        .show      (show_reg),
        .take      (en),
        .out_valid (vtx_out.valid),
        .out_data  (vtx_out.data),
        .out_ready (vtx_out.ready)
    );

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        vtx_out.valid && !vtx_out.ready |-> !tri_in.ready)
        else $error("input taken while output stalled");

    a_corner_range: assert property (@(posedge clk) disable iff (!rst_n)
        vtx_out.valid |-> vtx_out.data.corner != 2'd3)
        else $error("corner index out of range");

    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        vtx_out.valid && vtx_out.data.last |-> vtx_out.data.corner == 2'd2)
        else $error("last mark on an open triangle");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(valid_sreg))
        else $error("pipeline moved while held");
`endif

endmodule

`default_nettype wire

// ===== sim/tpc_checker.sv =====
// Scoreboard for the triangle plane clipper: watches both channels and config writes.
// Depends on tpc_pkg and tpc_if; predicts output vertices and counts mismatches.
`default_nettype none

module tpc_checker (
    input  logic        clk,
    input  logic        rst_n,
    tpc_if.sink         tri_mon,
    tpc_if.sink         vtx_mon,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import tpc_pkg::*;

    localparam int FRAC   = 16;
    localparam int QDEPTH = 1024;

    plane_t     plane;
    logic       show_colors;
    vtx_out_t   expected_vtx [QDEPTH];
    logic [9:0] wr_idx;
    logic [9:0] rd_idx;
    int         fill;

    assign pending = fill;

    // s + trunc(delta * num / den), quotient capped at 2^34, saturated to 32 bits
    function automatic coord_t cut_coord(longint s, longint delta, longint num,
                                         longint den);
        logic signed [127:0] prod;
        logic signed [127:0] quo;
        longint r;
        if (den == 0 || delta == 0 || num == 0)
            return coord_t'(s);
        prod = 128'(delta) * 128'(num);
        quo  = prod / 128'(den);
        if (quo > 128'sh4_0000_0000)
            quo = 128'sh4_0000_0000;
        if (quo < -128'sh4_0000_0000)
            quo = -128'sh4_0000_0000;
        r = s + longint'(quo);
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return coord_t'(r);
    endfunction

    function automatic vec_t cut_point(vec_t s, vec_t e, longint ds, longint de);
        vec_t o;
        for (int k = 0; k < 3; k++)
            o[k] = cut_coord(longint'(s[k]), longint'(e[k]) - longint'(s[k]),
                             -ds, de - ds);
        return o;
    endfunction

    function automatic longint plane_dot(longint x, longint y, longint z);
        return longint'(plane.nx) * x + longint'(plane.ny) * y + longint'(plane.nz) * z;
    endfunction

    task automatic push_vtx(vec_t p, logic [31:0] col, int cn, bit lst);
        vtx_out_t v;
        v.out_x = p[0];
        v.out_y = p[1];
        v.out_z = p[2];
        v.out_color = col;
        v.corner = 2'(cn);
        v.last = lst;
        expected_vtx[wr_idx] = v;
        wr_idx = wr_idx + 10'd1;
        fill++;
    endtask

    task automatic predict_clip(tri_in_t t);
        vec_t        v[3];
        logic [31:0] col[3];
        longint      d[3];
        longint      nq;
        longint      thr;
        int          ins[3];
        int          outs[3];
        int          n_in;
        int          n_out;
        vec_t        x0, x1;
        n_in = 0;
        n_out = 0;
        v[0] = '{t.a_z, t.a_y, t.a_x};
        v[1] = '{t.b_z, t.b_y, t.b_x};
        v[2] = '{t.c_z, t.c_y, t.c_x};
        col[0] = t.a_color;
        col[1] = t.b_color;
        col[2] = t.c_color;
        thr = ((64'sd1 << (2 * FRAC)) + 5) / 10;
        nq = plane_dot(longint'(plane.px), longint'(plane.py), longint'(plane.pz));
        for (int i = 0; i < 3; i++)
        begin
            d[i] = plane_dot(longint'(v[i][0]), longint'(v[i][1]), longint'(v[i][2])) - nq;
            if (d[i] >= -thr)
            begin
                ins[n_in] = i;
                n_in++;
            end
            else
            begin
                outs[n_out] = i;
                n_out++;
            end
        end
        if (n_in == 3)
        begin
            for (int i = 0; i < 3; i++)
                push_vtx(v[i], col[i], i, i == 2);
        end
        else if (n_in == 2)
        begin
            x0 = cut_point(v[ins[0]], v[outs[0]], d[ins[0]], d[outs[0]]);
            x1 = cut_point(v[ins[1]], v[outs[0]], d[ins[1]], d[outs[0]]);
            push_vtx(v[ins[0]], show_colors ? COL_GREEN : col[ins[0]], 0, 0);
            push_vtx(v[ins[1]], show_colors ? COL_GREEN : col[ins[1]], 1, 0);
            push_vtx(x0, show_colors ? COL_GREEN : col[outs[0]], 2, 0);
            push_vtx(v[ins[1]], show_colors ? COL_RED : col[ins[1]], 0, 0);
            push_vtx(x0, show_colors ? COL_RED : col[outs[0]], 1, 0);
            push_vtx(x1, show_colors ? COL_RED : col[outs[0]], 2, 1);
        end
        else if (n_in == 1)
        begin
            x0 = cut_point(v[ins[0]], v[outs[0]], d[ins[0]], d[outs[0]]);
            x1 = cut_point(v[ins[0]], v[outs[1]], d[ins[0]], d[outs[1]]);
            push_vtx(v[ins[0]], show_colors ? COL_BLUE : col[ins[0]], 0, 0);
            push_vtx(x0, show_colors ? COL_BLUE : col[outs[0]], 1, 0);
            push_vtx(x1, show_colors ? COL_BLUE : col[outs[1]], 2, 1);
        end
    endtask

    task automatic compare_vtx(vtx_out_t got);
        vtx_out_t exp_v;
        if (fill == 0)
        begin
            $error("unexpected vertex x=%h y=%h z=%h", got.out_x, got.out_y, got.out_z);
            fail_count++;
            return;
        end
        exp_v = expected_vtx[rd_idx];
        rd_idx = rd_idx + 10'd1;
        fill--;
        if (got.out_x !== exp_v.out_x)
        begin
            $error("out_x expected %h got %h", exp_v.out_x, got.out_x);
            fail_count++;
        end
        if (got.out_y !== exp_v.out_y)
        begin
            $error("out_y expected %h got %h", exp_v.out_y, got.out_y);
            fail_count++;
        end
        if (got.out_z !== exp_v.out_z)
        begin
            $error("out_z expected %h got %h", exp_v.out_z, got.out_z);
            fail_count++;
        end
        if (got.out_color !== exp_v.out_color)
        begin
            $error("out_color expected %h got %h", exp_v.out_color, got.out_color);
            fail_count++;
        end
        if (got.corner !== exp_v.corner)
        begin
            $error("corner expected %0d got %0d", exp_v.corner, got.corner);
            fail_count++;
        end
        if (got.last !== exp_v.last)
        begin
            $error("last expected %0d got %0d", exp_v.last, got.last);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane <= '{px: '0, py: '0, pz: '0, nx: '0, ny: '0, nz: 18'sd65536};
            show_colors <= 1'b0;
            wr_idx = '0;
            rd_idx = '0;
            fill = 0;
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_POINT_X: plane.px <= cfg_data;
                    CFG_POINT_Y: plane.py <= cfg_data;
                    CFG_POINT_Z: plane.pz <= cfg_data;
                    CFG_NORM_X:  plane.nx <= cfg_data[NW-1:0];
                    CFG_NORM_Y:  plane.ny <= cfg_data[NW-1:0];
                    CFG_NORM_Z:  plane.nz <= cfg_data[NW-1:0];
                    CFG_SHOW:    show_colors <= cfg_data[0];
                    default: ;
                endcase
            end
            // config is only written while idle, so old values apply here
            if (tri_mon.valid && tri_mon.ready)
                predict_clip(tri_mon.data);
            if (vtx_mon.valid && vtx_mon.ready)
                compare_vtx(vtx_mon.data);
        end
    end

endmodule

`default_nettype wire

// ===== sim/tb_triangle_plane_clipper_core.sv =====
// Top of the clipper testbench: clock, reset, config phases, triangle stimulus.
// Depends on tpc_pkg, tpc_if, the core and tpc_checker.
`default_nettype none

module tb_triangle_plane_clipper_core;
    timeunit 1ns;
    timeprecision 1ps;
    import tpc_pkg::*;

    localparam longint CYCLE_LIMIT = 400000;
    localparam int     DRAIN_CYCLES = 80;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          recv_idle_pct;
    longint      cycle_count = 0;

    tpc_if #(.data_t(tri_in_t))  tri_in ();
    tpc_if #(.data_t(vtx_out_t)) vtx_out ();

    triangle_plane_clipper_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tri_in    (tri_in.sink),
        .vtx_out   (vtx_out.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tpc_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .tri_mon    (tri_in.sink),
        .vtx_mon    (vtx_out.sink),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver stalls at random
    always @(negedge clk)
        vtx_out.ready <= ($urandom_range(99) >= recv_idle_pct);

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            default: return 32'($signed($urandom_range(40 * 65536)) - 20 * 65536);
        endcase
    endfunction

    function automatic tri_in_t rand_tri();
        tri_in_t t;
        t = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
             $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        t.a_x = rand_coord();
        t.a_y = rand_coord();
        t.a_z = rand_coord();
        t.b_x = rand_coord();
        t.b_y = rand_coord();
        t.b_z = rand_coord();
        t.c_x = rand_coord();
        t.c_y = rand_coord();
        t.c_z = rand_coord();
        return t;
    endfunction

    function automatic tri_in_t make_tri(int az, int bz, int cz);
        tri_in_t t;
        t = rand_tri();
        t.a_z = az;
        t.b_z = bz;
        t.c_z = cz;
        return t;
    endfunction

    // leaves valid high after the request is taken; the next call replaces or drops it, a drain drops it
    task automatic send_tri(tri_in_t t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            tri_in.valid <= 1'b0;
            @(negedge clk);
        end
        tri_in.valid <= 1'b1;
        tri_in.data  <= t;
        @(posedge clk);
        while (!tri_in.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        tri_in.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
    endtask

    task automatic load_plane(int px, int py, int pz, int nx, int ny, int nz, bit show);
        write_reg(CFG_POINT_X, px);
        write_reg(CFG_POINT_Y, py);
        write_reg(CFG_POINT_Z, pz);
        write_reg(CFG_NORM_X, nx);
        write_reg(CFG_NORM_Y, ny);
        write_reg(CFG_NORM_Z, nz);
        write_reg(CFG_SHOW, show);
        cfg_we <= 1'b0;
    endtask

    // mostly triangles near the plane so cuts are common
    task automatic random_phase(int count, int sidle, int ridle);
        tri_in_t t;
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(3) == 0)
                t = rand_tri();
            else
                t = make_tri($signed($urandom_range(8 * 65536)) - 4 * 65536,
                             $signed($urandom_range(8 * 65536)) - 4 * 65536,
                             $signed($urandom_range(8 * 65536)) - 4 * 65536);
            send_tri(t);
            if (i == count / 2 && sidle == 0)
            begin
                tri_in.valid <= 1'b0;
                @(negedge clk);
                while (pending != 0)
                    @(negedge clk);
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        tri_in.valid  = 1'b0;
        tri_in.data   = '0;
        send_idle_pct = 11;
        recv_idle_pct = 81;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // default plane z = 0 facing +z: all in, all out, two in, one in, threshold, extremes
        send_tri(make_tri(65536, 2, 0));
        send_tri(make_tri(-65536, -2 * 65536, 32'h8000_0000));
        send_tri(make_tri(65536, -65536, 3 * 65536));
        send_tri(make_tri(-65536, 65536, -5 * 65536));
        send_tri(make_tri(-6554, -6553, -6555));
        send_tri(make_tri(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        send_tri(make_tri(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        send_tri({{9{32'h8000_0000}}, {3{32'h0000_0000}}});
        send_tri({{9{32'h7FFF_FFFF}}, {3{32'hFFFF_FFFF}}});
        wait_drained();

        // debug colours and extreme registers
        load_plane(0, 0, 0, 0, 0, 65536, 1);
        send_tri(make_tri(65536, -65536, 3 * 65536));
        send_tri(make_tri(65536, -65536, -3 * 65536));
        send_tri(make_tri(65536, 65536, 65536));
        wait_drained();
        load_plane(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, -65536, 65536, -65536, 1);
        for (int i = 0; i < 6; i++)
            send_tri(rand_tri());
        wait_drained();
        load_plane(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h0002_0000, 32'h0001_FFFF, 32'h0003_FFFF, 0);
        for (int i = 0; i < 4; i++)
            send_tri(rand_tri());
        wait_drained();

        // offset and tilted planes, unnormalised too, random triangles
        load_plane(0, 0, 65536, 0, 0, 65536, 0);
        random_phase(70, 11, 81);
        wait_drained();
        load_plane(65536, -65536, 0, 46341, 0, -46341, 1);
        random_phase(70, 81, 11);
        wait_drained();
        load_plane(0, 0, 0, 30000, -20000, 50000, 0);
        random_phase(70, 0, 0);
        wait_drained();

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
